FILE: hw/rtl/spp_pkg.sv
package spp_pkg;

  // fixed widths of the stream fields
  localparam int unsigned TASK_ID_BITS  = 8;
  localparam int unsigned IN_PRIO_BITS  = 8;
  localparam int unsigned IN_BURST_BITS = 16;
  localparam int unsigned OUT_LEFT_BITS = 16;
  localparam int unsigned OUT_TIME_BITS = 32;
  localparam int unsigned IN_DATA_BITS  = 32;
  localparam int unsigned OUT_DATA_BITS = 64;

  // arrival order counter saturates at its top value
  localparam int unsigned ORDER_BITS = 16;
  localparam logic [ORDER_BITS-1:0] ORDER_MAX = 16'hFFFF;

  // command codes on the input tuser
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // status codes on the output tuser
  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

endpackage

FILE: hw/rtl/spp_pick.sv
// running selection of the most urgent candidate, one slot per cycle
// slots arrive in ascending index order, so a full tie keeps the lower slot
module spp_pick #(
  parameter int unsigned SLOT_BITS = 4,
  parameter int unsigned PRIO_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clear_i,
  input  logic                           valid_i,
  input  logic [SLOT_BITS-1:0]           idx_i,
  input  logic [PRIO_BITS-1:0]           prio_i,
  input  logic [spp_pkg::ORDER_BITS-1:0] order_i,
  output logic                           found_o,
  output logic [SLOT_BITS-1:0]           best_idx_o,
  output logic [PRIO_BITS-1:0]           best_prio_o
);

  logic                           found_q;
  logic [SLOT_BITS-1:0]           best_idx_q;
  logic [PRIO_BITS-1:0]           best_prio_q;
  logic [spp_pkg::ORDER_BITS-1:0] best_order_q;
  logic                           better;

  // strictly more urgent: smaller priority, then earlier arrival
  assign better = !found_q || (prio_i < best_prio_q) ||
                  ((prio_i == best_prio_q) && (order_i < best_order_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else if (valid_i && better) begin
      found_q <= 1'b1;
    end
  end

  // payload of the current best candidate
  always_ff @(posedge clk_i) begin
    if (!clear_i && valid_i && better) begin
      best_idx_q   <= idx_i;
      best_prio_q  <= prio_i;
      best_order_q <= order_i;
    end
  end

  assign found_o     = found_q;
  assign best_idx_o  = best_idx_q;
  assign best_prio_o = best_prio_q;

endmodule

FILE: hw/rtl/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler.
// Input stream: tuser carries the command (arrive or tick), tdata the task id,
// priority and burst of an arriving task. Every input transfer gives exactly
// one output transfer: tuser the status, tdata the task that ran, its
// remaining time, a done flag and the time after the item.
// The task table sits in a single-port-write, registered-read memory of
// MAX_TASKS entries; the occupancy bits are flip-flops.
// An arrive goes from S_IDLE through S_OUT into the output register: the lowest
// free slot is found from the occupancy bits and written at once.
// A tick steps through S_SCAN, S_DRAIN, S_DECIDE, S_READ, S_OUT (no S_READ when idle):
// the memory is read one slot a cycle to find the most urgent waiting task, then the
// slot that runs is read again and written back with its burst decremented.
// Items are handled one at a time; the next input is taken once the previous
// result sits in the output register, even while that result is stalled.
// If the receiver holds tready low, the following result waits in its last
// state until the output register frees.
// Reset empties the table, clears the running task, the time and the
// arrival counter; no memory clearing pass is needed.
module preemptive_priority_scheduler_top #(
  parameter int unsigned MAX_TASKS     = 16,
  parameter int unsigned PRIORITY_BITS = 8,
  parameter int unsigned BURST_BITS    = 16,
  parameter int unsigned TIME_BITS     = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // task_id [7:0], priority_req [15:8], burst [31:16]
  input  logic [spp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata_i,
  // command [0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // ran_task [7:0], left_time [23:8], done_res [24], clock_now [56:25], zero above
  output logic [spp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]                         m_axis_tuser_o
);

  localparam int unsigned SLOT_BITS = $clog2(MAX_TASKS);
  localparam int unsigned PAD_BITS  = spp_pkg::OUT_DATA_BITS - spp_pkg::TASK_ID_BITS -
                                      spp_pkg::OUT_LEFT_BITS - 1 - spp_pkg::OUT_TIME_BITS;

  typedef struct packed {
    logic [spp_pkg::TASK_ID_BITS-1:0] tid;
    logic [PRIORITY_BITS-1:0]         prio;
    logic [BURST_BITS-1:0]            left;
    logic [spp_pkg::ORDER_BITS-1:0]   order;
  } slot_t;

  typedef struct packed {
    spp_pkg::status_e                  status;
    logic [spp_pkg::TASK_ID_BITS-1:0]  ran;
    logic [spp_pkg::OUT_LEFT_BITS-1:0] left;
    logic                              done;
    logic [spp_pkg::OUT_TIME_BITS-1:0] clock_now;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_READ,
    S_OUT
  } state_e;

  state_e                         state_q;
  logic [MAX_TASKS-1:0]           used_q;
  logic [SLOT_BITS-1:0]           cur_slot_q;
  logic                           cur_valid_q;
  logic [PRIORITY_BITS-1:0]       cur_prio_q;
  logic [TIME_BITS-1:0]           time_q;
  logic [spp_pkg::ORDER_BITS-1:0] order_q;
  logic [SLOT_BITS-1:0]           scan_q;
  logic                           rd_valid_q;
  logic [SLOT_BITS-1:0]           rd_idx_q;
  logic [SLOT_BITS-1:0]           run_q;
  result_t                        res_q;
  result_t                        out_q;
  logic                           out_valid_q;

  // task table memory
  slot_t                mem [MAX_TASKS];
  slot_t                rd_data_q;
  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  slot_t                mem_wdata;
  logic [SLOT_BITS-1:0] mem_raddr;

  // input field decode
  logic                             in_fire;
  logic [spp_pkg::TASK_ID_BITS-1:0] in_tid;
  logic [PRIORITY_BITS-1:0]         in_prio;
  logic [BURST_BITS-1:0]            in_burst;
  logic [BURST_BITS-1:0]            burst_fix;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_tid   = s_axis_tdata_i[7:0];
  assign in_prio  = PRIORITY_BITS'(s_axis_tdata_i[15:8]);
  assign in_burst = BURST_BITS'(s_axis_tdata_i[31:16]);
  assign burst_fix = (in_burst == '0) ? BURST_BITS'(1) : in_burst;

  // lowest free slot
  logic                 free_found;
  logic [SLOT_BITS-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_BITS'(i);
      end
    end
  end

  // saturating time step
  logic [TIME_BITS-1:0] time_inc;
  assign time_inc = (time_q == '1) ? time_q : time_q + 1'b1;

  // scan candidate: used and not the running task
  logic                 pick_valid;
  logic                 best_found;
  logic [SLOT_BITS-1:0] best_idx;
  logic [PRIORITY_BITS-1:0] best_prio;

  assign pick_valid = rd_valid_q && used_q[rd_idx_q] &&
                      !(cur_valid_q && (rd_idx_q == cur_slot_q));

  spp_pick #(
    .SLOT_BITS (SLOT_BITS),
    .PRIO_BITS (PRIORITY_BITS)
  ) u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (in_fire && (s_axis_tuser_i == spp_pkg::CMD_TICK)),
    .valid_i     (pick_valid),
    .idx_i       (rd_idx_q),
    .prio_i      (rd_data_q.prio),
    .order_i     (rd_data_q.order),
    .found_o     (best_found),
    .best_idx_o  (best_idx),
    .best_prio_o (best_prio)
  );

  // choice of the slot to run
  logic                 cur_ok;
  logic                 run_any;
  logic [SLOT_BITS-1:0] run_sel;

  always_comb begin
    cur_ok = cur_valid_q && used_q[cur_slot_q];
    if (cur_ok) begin
      run_any = 1'b1;
      run_sel = (best_found && (best_prio < cur_prio_q)) ? best_idx : cur_slot_q;
    end else begin
      run_any = best_found;
      run_sel = best_idx;
    end
  end

  // decremented burst of the slot that runs
  logic [BURST_BITS-1:0] left_dec;
  assign left_dec = rd_data_q.left - 1'b1;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx;
    mem_wdata = slot_t'{tid: in_tid, prio: in_prio, left: burst_fix, order: order_q};
    mem_raddr = scan_q;
    unique case (state_q)
      S_IDLE: begin
        mem_we = in_fire && (s_axis_tuser_i == spp_pkg::CMD_ARRIVE) && free_found;
      end
      S_DECIDE: begin
        mem_raddr = run_sel;
      end
      S_READ: begin
        mem_we         = 1'b1;
        mem_waddr      = run_q;
        mem_wdata      = rd_data_q;
        mem_wdata.left = left_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[mem_raddr];
  end

  // sequencer with scheduler state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      cur_prio_q  <= '0;
      time_q      <= '0;
      order_q     <= '0;
      scan_q      <= '0;
      rd_valid_q  <= 1'b0;
      rd_idx_q    <= '0;
      run_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == S_SCAN);
      rd_idx_q   <= scan_q;
      if (out_valid_q && m_axis_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      // remember the running task's priority as it passes in the scan
      if (rd_valid_q && cur_valid_q && (rd_idx_q == cur_slot_q)) begin
        cur_prio_q <= rd_data_q.prio;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser_i == spp_pkg::CMD_TICK) begin
              scan_q  <= '0;
              state_q <= S_SCAN;
            end else begin
              res_q <= result_t'{
                status:    free_found ? spp_pkg::ST_ACCEPTED : spp_pkg::ST_DROPPED,
                ran:       '0,
                left:      '0,
                done:      1'b0,
                clock_now: spp_pkg::OUT_TIME_BITS'(time_q)
              };
              if (free_found) begin
                used_q[free_idx] <= 1'b1;
                if (order_q != spp_pkg::ORDER_MAX) begin
                  order_q <= order_q + 1'b1;
                end
              end
              state_q <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          if (scan_q == SLOT_BITS'(MAX_TASKS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          run_q <= run_sel;
          if (run_any) begin
            state_q <= S_READ;
          end else begin
            time_q      <= time_inc;
            cur_valid_q <= 1'b0;
            res_q <= result_t'{
              status:    spp_pkg::ST_IDLE,
              ran:       '0,
              left:      '0,
              done:      1'b0,
              clock_now: spp_pkg::OUT_TIME_BITS'(time_inc)
            };
            state_q <= S_OUT;
          end
        end
        S_READ: begin
          time_q <= time_inc;
          res_q <= result_t'{
            status:    spp_pkg::ST_RAN,
            ran:       rd_data_q.tid,
            left:      spp_pkg::OUT_LEFT_BITS'(left_dec),
            done:      (left_dec == '0),
            clock_now: spp_pkg::OUT_TIME_BITS'(time_inc)
          };
          if (left_dec == '0) begin
            used_q[run_q] <= 1'b0;
            cur_valid_q   <= 1'b0;
          end else begin
            cur_slot_q  <= run_q;
            cur_valid_q <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {{PAD_BITS{1'b0}}, out_q.clock_now, out_q.done,
                            out_q.left, out_q.ran};

endmodule
